@@ design/tree_allreduce_node_macros.svh @@
// assertion macros for the tree allreduce node
// used by tree_allreduce_node.sv, expects clk_i and rst_ni in scope
`ifndef TREE_ALLREDUCE_NODE_MACROS_SVH
`define TREE_ALLREDUCE_NODE_MACROS_SVH

// same-cycle implication
`define TAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tar_pkg.sv @@
// shared widths, codes and saturation limits of the tree allreduce node
// no dependencies
`default_nettype none

package tar_pkg;

  localparam int unsigned VAL_W  = 64;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned RANK_W = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CFG_W  = 4;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_CHILD  = 2'd1;
  localparam logic [1:0] ACT_PARENT = 2'd2;

  localparam logic [1:0] OP_SUM  = 2'd0;
  localparam logic [1:0] OP_PROD = 2'd1;
  localparam logic [1:0] OP_MIN  = 2'd2;
  localparam logic [1:0] OP_MAX  = 2'd3;

  localparam logic [1:0] ROLE_ROOT = 2'd0;
  localparam logic [1:0] ROLE_LEAF = 2'd2;

  localparam logic [1:0] KIND_PARENT = 2'd0;
  localparam logic [1:0] KIND_CHILD  = 2'd1;
  localparam logic [1:0] KIND_LOCAL  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [CFG_W-1:0] CFG_ROLE   = 4'd0;
  localparam logic [CFG_W-1:0] CFG_COUNT  = 4'd1;
  localparam logic [CFG_W-1:0] CFG_PARENT = 4'd2;
  localparam logic [CFG_W-1:0] CFG_LEN    = 4'd3;

  localparam logic [VAL_W-1:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_MIN = 64'h8000_0000_0000_0000;

endpackage

`default_nettype wire

@@ design/tar_mul.sv @@
// saturating signed q32.32 multiplier
// partial products registered, then summed and saturated; uses tar_pkg
`default_nettype none

module tar_mul (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic                      clear_i,
  input  wire logic [tar_pkg::VAL_W-1:0] a_i,
  input  wire logic [tar_pkg::VAL_W-1:0] b_i,
  output      logic                      done_o,
  output      logic [tar_pkg::VAL_W-1:0] prod_o
);

  logic [63:0]  ma, mb;
  logic [63:0]  ll_d, lh_d, hl_d, hh_d;
  logic [63:0]  ll_q, lh_q, hl_q, hh_q;
  logic         neg_q;
  logic         done_q;
  logic [127:0] full;
  logic [63:0]  mag;
  logic         ovf;

  assign ma = a_i[63] ? (64'd0 - a_i) : a_i;
  assign mb = b_i[63] ? (64'd0 - b_i) : b_i;

  assign ll_d = {32'd0, ma[31:0]}  * {32'd0, mb[31:0]};
  assign lh_d = {32'd0, ma[31:0]}  * {32'd0, mb[63:32]};
  assign hl_d = {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
  assign hh_d = {32'd0, ma[63:32]} * {32'd0, mb[63:32]};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ll_q  <= ll_d;
      lh_q  <= lh_d;
      hl_q  <= hl_d;
      hh_q  <= hh_d;
      neg_q <= a_i[63] ^ b_i[63];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else if (start_i) begin
      done_q <= 1'b1;
    end else if (clear_i) begin
      done_q <= 1'b0;
    end
  end

  assign full = {hh_q, 64'd0} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0} + {64'd0, ll_q};
  assign ovf  = |full[127:96];
  assign mag  = full[95:32];

  always_comb begin
    if (ovf) begin
      prod_o = neg_q ? tar_pkg::SAT_MIN : tar_pkg::SAT_MAX;
    end else if (neg_q) begin
      prod_o = (mag > tar_pkg::SAT_MIN) ? tar_pkg::SAT_MIN : (64'd0 - mag);
    end else begin
      prod_o = (mag > tar_pkg::SAT_MAX) ? tar_pkg::SAT_MAX : mag;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

@@ design/tree_allreduce_node.sv @@
// Tree allreduce node.
// Input channel (in_valid_i / in_stall_o) carries action, reduce_op and value;
// one word is taken when valid is high and stall is low. Output channel
// (out_valid_o / out_stall_i) carries kind, child_index, dest_rank,
// result_value, msg_len and last; last marks the final result of an input word.
// Configuration registers are written over cfg_valid_i / cfg_ready_o with
// cfg_index_i and cfg_data_i; ready is always high, write only while idle.
// A result is registered in the output stage once the input register hands its
// word on; a child word under the product operation first waits there for the
// multiplier's registered partial products. Throughput: one input word per cycle
// while each gives at most one result, waits on no product and the receiver does not
// stall; a broadcast holds the output stage for one child word per child and a final
// local word, one per cycle unless stalled; the input register takes the next word.
// Reset clears the configuration, returns the node to idle with a zero
// accumulator and empties both registers. A stalled receiver holds the
// output word; the input register then fills and in_stall_o rises.
// depends on tar_pkg, tar_mul and tree_allreduce_node_macros.svh
`default_nettype none
`include "tree_allreduce_node_macros.svh"

module tree_allreduce_node #(
  parameter int unsigned MAX_CHILDREN = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output      logic                       cfg_ready_o,
  input  wire logic [tar_pkg::CFG_W-1:0]  cfg_index_i,
  input  wire logic [15:0]                cfg_data_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic [1:0]                 reduce_op_i,
  input  wire logic [tar_pkg::VAL_W-1:0]  value_i,
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [1:0]                 kind_o,
  output      logic [tar_pkg::IDX_W-1:0]  child_index_o,
  output      logic [tar_pkg::RANK_W-1:0] dest_rank_o,
  output      logic [tar_pkg::VAL_W-1:0]  result_value_o,
  output      logic [tar_pkg::LEN_W-1:0]  msg_len_o,
  output      logic                       last_o
);

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT_CH, PH_WAIT_PAR} phase_e;

  function automatic logic [tar_pkg::VAL_W-1:0] sat_add(logic [tar_pkg::VAL_W-1:0] a,
                                                       logic [tar_pkg::VAL_W-1:0] b);
    logic [tar_pkg::VAL_W-1:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? tar_pkg::SAT_MIN : tar_pkg::SAT_MAX;
    end
    return s;
  endfunction

  // configuration
  logic [1:0]                 role_q;
  logic [tar_pkg::CNT_W-1:0]  count_q;
  logic [tar_pkg::RANK_W-1:0] prank_q;
  logic [tar_pkg::LEN_W-1:0]  mlen_q;

  // input register
  logic                      in_vld_q;
  logic [1:0]                in_act_q;
  logic [1:0]                in_op_q;
  logic [tar_pkg::VAL_W-1:0] in_val_q;
  logic                      in_acc;
  logic                      in_take;

  // node state
  phase_e                    phase_q, phase_d;
  logic [tar_pkg::VAL_W-1:0] acc_q, acc_d;
  logic [1:0]                op_q, op_d;
  logic [tar_pkg::CNT_W-1:0] rc_q, rc_d;

  // output stage
  logic                       out_vld_q, out_vld_d;
  logic [1:0]                 kind_q, kind_d;
  logic [tar_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [tar_pkg::RANK_W-1:0] dest_q, dest_d;
  logic [tar_pkg::VAL_W-1:0]  rval_q, rval_d;
  logic [tar_pkg::LEN_W-1:0]  len_q, len_d;
  logic                       last_q, last_d;
  logic [tar_pkg::CNT_W-1:0]  bc_idx_q, bc_idx_d;
  logic [tar_pkg::CNT_W-1:0]  bc_n_q, bc_n_d;
  logic [tar_pkg::CNT_W-1:0]  bc_next;
  logic                       out_free;
  logic                       bc_more;
  logic                       eng_go;

  // engine
  logic [tar_pkg::CNT_W-1:0]  eff_n;
  logic                       need_mul;
  logic                       mul_start;
  logic                       mul_done;
  logic [tar_pkg::VAL_W-1:0]  mul_p;
  logic [tar_pkg::VAL_W-1:0]  combined;
  logic [tar_pkg::CNT_W-1:0]  rc_inc;
  logic                       finish;
  logic [tar_pkg::VAL_W-1:0]  fin_val;
  logic                       job_vld;
  logic                       job_bc;
  logic [1:0]                 job_kind;
  logic [tar_pkg::RANK_W-1:0] job_dest;
  logic [tar_pkg::VAL_W-1:0]  job_val;
  logic [tar_pkg::LEN_W-1:0]  job_len;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q  <= '0;
      count_q <= '0;
      prank_q <= '0;
      mlen_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tar_pkg::CFG_ROLE:   role_q  <= cfg_data_i[1:0];
        tar_pkg::CFG_COUNT:  count_q <= cfg_data_i[tar_pkg::CNT_W-1:0];
        tar_pkg::CFG_PARENT: prank_q <= cfg_data_i;
        tar_pkg::CFG_LEN:    mlen_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_n = (32'(count_q) > MAX_CHILDREN) ? tar_pkg::CNT_W'(MAX_CHILDREN) : count_q;

  // input register
  assign in_stall_o = in_vld_q && !in_take;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (in_take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_act_q <= action_i;
      in_op_q  <= reduce_op_i;
      in_val_q <= value_i;
    end
  end

  // product unit
  assign need_mul  = (in_act_q == tar_pkg::ACT_CHILD) && (phase_q == PH_WAIT_CH) &&
                     (op_q == tar_pkg::OP_PROD);
  assign mul_start = in_vld_q && need_mul && !mul_done;

  tar_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .clear_i (in_take),
    .a_i     (acc_q),
    .b_i     (in_val_q),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  // output stage handshake
  assign out_free = !out_vld_q || !out_stall_i;
  assign bc_more  = out_vld_q && !last_q;
  assign eng_go   = out_free && !bc_more;
  assign in_take  = in_vld_q && eng_go && (!need_mul || mul_done);

  always_comb begin
    case (op_q)
      tar_pkg::OP_SUM:  combined = sat_add(acc_q, in_val_q);
      tar_pkg::OP_PROD: combined = mul_p;
      tar_pkg::OP_MIN:  combined = ($signed(acc_q) < $signed(in_val_q)) ? acc_q : in_val_q;
      default:          combined = ($signed(in_val_q) < $signed(acc_q)) ? acc_q : in_val_q;
    endcase
  end

  assign rc_inc = rc_q + tar_pkg::CNT_W'(1);

  // event handling
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    op_d     = op_q;
    rc_d     = rc_q;
    finish   = 1'b0;
    fin_val  = acc_q;
    job_vld  = 1'b0;
    job_bc   = 1'b0;
    job_kind = tar_pkg::KIND_ERROR;
    job_dest = '0;
    job_val  = '0;
    job_len  = '0;
    case (in_act_q)
      tar_pkg::ACT_START: begin
        if (phase_q == PH_IDLE) begin
          acc_d = in_val_q;
          op_d  = in_op_q;
          rc_d  = '0;
          if (role_q == tar_pkg::ROLE_LEAF) begin
            job_vld  = 1'b1;
            job_kind = tar_pkg::KIND_PARENT;
            job_dest = prank_q;
            job_val  = in_val_q;
            job_len  = mlen_q;
            phase_d  = PH_WAIT_PAR;
          end else begin
            phase_d = PH_WAIT_CH;
            if (eff_n == '0) begin
              finish  = 1'b1;
              fin_val = in_val_q;
            end
          end
        end else begin
          job_vld = 1'b1;
        end
      end
      tar_pkg::ACT_CHILD: begin
        if (phase_q == PH_WAIT_CH) begin
          rc_d  = rc_inc;
          acc_d = combined;
          if (rc_inc >= eff_n) begin
            finish  = 1'b1;
            fin_val = combined;
          end
        end else begin
          job_vld = 1'b1;
        end
      end
      tar_pkg::ACT_PARENT: begin
        if (phase_q == PH_WAIT_PAR) begin
          acc_d   = in_val_q;
          job_vld = 1'b1;
          job_bc  = 1'b1;
          job_val = in_val_q;
          phase_d = PH_IDLE;
        end else begin
          job_vld = 1'b1;
        end
      end
      default: begin
        job_vld = 1'b1;
      end
    endcase
    if (finish) begin
      rc_d    = '0;
      job_vld = 1'b1;
      job_val = fin_val;
      if (role_q == tar_pkg::ROLE_ROOT) begin
        job_bc  = 1'b1;
        phase_d = PH_IDLE;
      end else begin
        job_kind = tar_pkg::KIND_PARENT;
        job_dest = prank_q;
        job_len  = mlen_q;
        phase_d  = PH_WAIT_PAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      op_q    <= tar_pkg::OP_SUM;
      rc_q    <= '0;
    end else if (in_take) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      op_q    <= op_d;
      rc_q    <= rc_d;
    end
  end

  // result sequencing
  assign bc_next = bc_idx_q + tar_pkg::CNT_W'(1);

  always_comb begin
    out_vld_d = out_vld_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    dest_d    = dest_q;
    rval_d    = rval_q;
    len_d     = len_q;
    last_d    = last_q;
    bc_idx_d  = bc_idx_q;
    bc_n_d    = bc_n_q;
    if (out_free) begin
      if (bc_more) begin
        out_vld_d = 1'b1;
        if (bc_next < bc_n_q) begin
          kind_d   = tar_pkg::KIND_CHILD;
          idx_d    = bc_next[tar_pkg::IDX_W-1:0];
          bc_idx_d = bc_next;
          last_d   = 1'b0;
        end else begin
          kind_d = tar_pkg::KIND_LOCAL;
          idx_d  = '0;
          len_d  = '0;
          last_d = 1'b1;
        end
      end else if (in_take && job_vld) begin
        out_vld_d = 1'b1;
        rval_d    = job_val;
        dest_d    = job_dest;
        idx_d     = '0;
        bc_idx_d  = '0;
        bc_n_d    = eff_n;
        if (job_bc) begin
          if (eff_n == '0) begin
            kind_d = tar_pkg::KIND_LOCAL;
            len_d  = '0;
            last_d = 1'b1;
          end else begin
            kind_d = tar_pkg::KIND_CHILD;
            len_d  = mlen_q;
            last_d = 1'b0;
          end
        end else begin
          kind_d = job_kind;
          len_d  = job_len;
          last_d = 1'b1;
        end
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      last_q    <= 1'b1;
    end else begin
      out_vld_q <= out_vld_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    idx_q    <= idx_d;
    dest_q   <= dest_d;
    rval_q   <= rval_d;
    len_q    <= len_d;
    bc_idx_q <= bc_idx_d;
    bc_n_q   <= bc_n_d;
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = kind_q;
  assign child_index_o  = idx_q;
  assign dest_rank_o    = dest_q;
  assign result_value_o = rval_q;
  assign msg_len_o      = len_q;
  assign last_o         = last_q;

  // checks
  `TAR_ASSERT_IMP(a_nonlast_is_child, out_vld_q && !last_q, kind_q == tar_pkg::KIND_CHILD, "non-final result is not a child word")
  `TAR_ASSERT_IMP(a_count_idle, phase_q != PH_WAIT_CH, rc_q == '0, "child count left over outside child wait")
  `TAR_ASSERT_IMP(a_mul_has_item, mul_done, in_vld_q && need_mul, "product pending without its input word")
  `TAR_ASSERT_NXT(a_mul_done, mul_start, mul_done, "product not ready after start")

endmodule

`default_nettype wire
